// File: design/lpnm_pkg.sv
// Shared types and constants for the light table nearest color search.
package lpnm_pkg;

	// Field widths.
	localparam int PIX_W      = 16;
	localparam int IDX_W      = 8;
	localparam int GAIN_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int RB_W       = 5;
	localparam int G_W        = 6;
	localparam int RAW_W      = 6;
	localparam int NUM_W      = 17;
	localparam int QUO_W      = 8;
	localparam int DIST_W     = 15;

	// Default number of searched table entries.
	localparam int DEFAULT_TABLE_ENTRIES = 256;

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RESET = 11'd1000;

	// Tint blend multipliers: (c*500 + gain*50) / 1000.
	localparam logic [NUM_W-1:0] TINT_C_MUL = 17'd500;
	localparam logic [NUM_W-1:0] TINT_G_MUL = 17'd50;

	// Divide by 1000 as a multiply by ceil(2^27/1000) and a shift by 27.
	// Exact for every numerator below 2^17.
	localparam int DIV_SHIFT = 27;
	localparam int PROD_W    = NUM_W + 18;
	localparam logic [PROD_W-1:0] DIV_RECIP = 35'd134218;

	// Component clamp limits.
	localparam logic [QUO_W-1:0] RB_MAX = 8'd31;
	localparam logic [QUO_W-1:0] G_MAX  = 8'd63;

	// Component table layout: eight red, eight green, four blue levels.
	localparam int N_RED   = 8;
	localparam int N_GREEN = 8;
	localparam int N_BLUE  = 4;
	localparam int N_SLOTS = N_RED + N_GREEN + N_BLUE;
	localparam int SLOT_W  = $clog2(N_SLOTS);

	// Larger than any possible weighted distance.
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_GAIN   = 2'd0,
		REG_GREEN_GAIN = 2'd1,
		REG_BLUE_GAIN  = 2'd2,
		REG_TINT_MODE  = 2'd3
	} cfg_reg_t;

	// Configuration register set.
	typedef struct packed {
		logic [GAIN_W-1:0] red_gain;
		logic [GAIN_W-1:0] green_gain;
		logic [GAIN_W-1:0] blue_gain;
		logic              tint_mode;
	} cfg_t;

	// One table candidate on its way through the distance unit.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] color;
	} cand_t;

endpackage

// File: design/lpnm_comp_table.sv
// Scaled color component table, rebuilt by a shared multiply and divide pipeline.
module lpnm_comp_table
	import lpnm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             restart,
	input  logic [IDX_W-1:0] rd_idx,
	output logic             ready,
	output logic [PIX_W-1:0] rd_color
);

	// Scaled component levels.
	logic [RB_W-1:0] r_tab_q [N_RED];
	logic [G_W-1:0]  g_tab_q [N_GREEN];
	logic [RB_W-1:0] b_tab_q [N_BLUE];

	logic [SLOT_W-1:0] slot_q;
	logic              busy_q;
	logic              valid_s1;
	logic              valid_s2;
	logic [SLOT_W-1:0] slot_s1;
	logic [SLOT_W-1:0] slot_s2;
	logic [NUM_W-1:0]  num_s1;
	logic [QUO_W-1:0]  quo_s2;

	logic              is_red;
	logic              is_green;
	logic [RAW_W-1:0]  raw;
	logic [GAIN_W-1:0] gain;
	logic [NUM_W-1:0]  raw_w;
	logic [NUM_W-1:0]  gain_w;
	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  lim;
	logic [QUO_W-1:0]  clamped;
	logic              last_slot;

	// Select the raw level and gain of the slot being issued.
	assign is_red    = slot_q < SLOT_W'(N_RED);
	assign is_green  = !is_red && (slot_q < SLOT_W'(N_RED + N_GREEN));
	assign raw       = (is_red || is_green) ? {slot_q[2:0], 3'b000} : {1'b0, slot_q[1:0], 3'b000};
	assign gain      = is_red ? cfg.red_gain : (is_green ? cfg.green_gain : cfg.blue_gain);
	assign raw_w     = NUM_W'(raw);
	assign gain_w    = NUM_W'(gain);
	assign num       = cfg.tint_mode ? (raw_w * TINT_C_MUL + gain_w * TINT_G_MUL)
	                                 : (raw_w * gain_w);
	assign last_slot = slot_q == SLOT_W'(N_SLOTS - 1);

	// Issue sequencer: one slot per cycle, restarted by any register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= busy_q && !restart;
			valid_s2 <= valid_s1;
			if (restart) begin
				slot_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (last_slot) begin
					busy_q <= 1'b0;
				end
				slot_q <= last_slot ? '0 : slot_q + 1'b1;
			end
		end
	end

	// Divide by 1000 through the reciprocal multiply.
	assign prod = PROD_W'(num_s1) * DIV_RECIP;

	always_ff @(posedge clk) begin
		slot_s1 <= slot_q;
		num_s1  <= num;
		slot_s2 <= slot_s1;
		quo_s2  <= prod[DIV_SHIFT +: QUO_W];
	end

	// Clamp and store the finished level.
	assign lim     = ((slot_s2 >= SLOT_W'(N_RED)) && (slot_s2 < SLOT_W'(N_RED + N_GREEN)))
	                 ? G_MAX : RB_MAX;
	assign clamped = (quo_s2 > lim) ? lim : quo_s2;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (slot_s2 < SLOT_W'(N_RED)) begin
				r_tab_q[slot_s2[2:0]] <= clamped[RB_W-1:0];
			end else if (slot_s2 < SLOT_W'(N_RED + N_GREEN)) begin
				g_tab_q[slot_s2[2:0]] <= clamped[G_W-1:0];
			end else begin
				b_tab_q[slot_s2[1:0]] <= clamped[RB_W-1:0];
			end
		end
	end

	assign ready    = !busy_q && !valid_s1 && !valid_s2;
	assign rd_color = {r_tab_q[rd_idx[7:5]], g_tab_q[rd_idx[4:2]], b_tab_q[rd_idx[1:0]]};

endmodule

// File: design/lpnm_dist_unit.sv
// Two-stage squared color distance unit, one candidate per cycle.
module lpnm_dist_unit
	import lpnm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PIX_W-1:0]  target,
	input  logic              weighted,
	input  cand_t             cand_in,
	output cand_t             cand_out,
	output logic [DIST_W-1:0] cand_dist
);

	cand_t             cand_s1;
	cand_t             cand_s2;
	logic [RB_W-1:0]   dr_s1;
	logic [G_W-1:0]    dg_s1;
	logic [RB_W-1:0]   db_s1;
	logic [DIST_W-1:0] dist_s2;

	logic [RB_W-1:0]   tr;
	logic [RB_W-1:0]   cr;
	logic [G_W-1:0]    tg;
	logic [G_W-1:0]    cg;
	logic [RB_W-1:0]   tb;
	logic [RB_W-1:0]   cb;
	logic [DIST_W-1:0] sq_r;
	logic [DIST_W-1:0] sq_g;
	logic [DIST_W-1:0] sq_b;
	logic [DIST_W-1:0] sum;

	// Split both colors into components.
	assign tr = target[15:11];
	assign tg = target[10:5];
	assign tb = target[4:0];
	assign cr = cand_in.color[15:11];
	assign cg = cand_in.color[10:5];
	assign cb = cand_in.color[4:0];

	// Stage 1: absolute component differences.
	always_ff @(posedge clk) begin
		dr_s1 <= (tr >= cr) ? tr - cr : cr - tr;
		dg_s1 <= (tg >= cg) ? tg - cg : cg - tg;
		db_s1 <= (tb >= cb) ? tb - cb : cb - tb;
	end

	// Stage 2: squares and the 2:4:2 or unweighted sum.
	assign sq_r = DIST_W'(dr_s1) * DIST_W'(dr_s1);
	assign sq_g = DIST_W'(dg_s1) * DIST_W'(dg_s1);
	assign sq_b = DIST_W'(db_s1) * DIST_W'(db_s1);
	assign sum  = weighted ? ((sq_r << 1) + (sq_g << 2) + (sq_b << 1)) : (sq_r + sq_g + sq_b);

	always_ff @(posedge clk) begin
		dist_s2 <= sum;
	end

	// Candidates and their valid bits travel with the distance stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= '0;
			cand_s2 <= '0;
		end else begin
			cand_s1 <= cand_in;
			cand_s2 <= cand_s1;
		end
	end

	assign cand_out  = cand_s2;
	assign cand_dist = dist_s2;

endmodule

// File: design/lit_palette_nearest_match.sv
// Top level of the light table nearest color search.
//
// Each pixel request is compared against light table entries 0..TABLE_ENTRIES-1, one entry
// per clock through a two-stage distance unit; in index mode the target color is looked
// up in the table first, and a zero RGB565 pixel in pixel mode returns without a search. The
// table is built from twenty scaled component levels held in registers; after reset and
// after every configuration write a shared multiply and divide pipeline rebuilds them, and
// no pixel is accepted until it is done. The result sits in an output register, so a new
// pixel is taken while the previous result still waits downstream.
module lit_palette_nearest_match
	import lpnm_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Pixel requests.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,    // [15:0] pixel
	input  logic                 s_tuser,    // [0] pixel_mode
	// Results.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,    // [15:0] pixel_out
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_TARGET = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	logic              mode_q;
	logic [PIX_W-1:0]  pix_q;
	logic [PIX_W-1:0]  target_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PIX_W-1:0]  best_color_q;
	logic              m_tvalid_q;
	logic [PIX_W-1:0]  m_tdata_q;
	logic              drain_cnt_q;

	logic              cfg_acc;
	logic              in_acc;
	logic              tab_ready;
	logic [IDX_W-1:0]  rd_idx;
	logic [PIX_W-1:0]  rd_color;
	cand_t             cand_in;
	cand_t             cand_out;
	logic [DIST_W-1:0] cand_dist;
	logic              last_entry;
	logic              out_free;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_gain   <= GAIN_RESET;
			cfg_q.green_gain <= GAIN_RESET;
			cfg_q.blue_gain  <= GAIN_RESET;
			cfg_q.tint_mode  <= 1'b0;
		end else if (cfg_acc) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED_GAIN: begin
					cfg_q.red_gain <= cfg_data;
				end
				REG_GREEN_GAIN: begin
					cfg_q.green_gain <= cfg_data;
				end
				REG_BLUE_GAIN: begin
					cfg_q.blue_gain <= cfg_data;
				end
				REG_TINT_MODE: begin
					cfg_q.tint_mode <= cfg_data[0];
				end
			endcase
		end
	end

	// Component table and its lookup port.
	assign rd_idx = (state_q == ST_TARGET) ? pix_q[IDX_W-1:0] : IDX_W'(cnt_q);

	lpnm_comp_table u_comp_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.restart  (cfg_acc),
		.rd_idx   (rd_idx),
		.ready    (tab_ready),
		.rd_color (rd_color)
	);

	// Distance unit fed one table entry per search cycle.
	assign cand_in = '{valid: (state_q == ST_SEARCH), idx: IDX_W'(cnt_q), color: rd_color};

	lpnm_dist_unit u_dist_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.weighted  (mode_q),
		.cand_in   (cand_in),
		.cand_out  (cand_out),
		.cand_dist (cand_dist)
	);

	assign s_tready   = (state_q == ST_IDLE) && tab_ready && !cfg_valid;
	assign in_acc     = s_tvalid && s_tready;
	assign last_entry = cnt_q == CNT_W'(TABLE_ENTRIES - 1);
	assign out_free   = !m_tvalid_q || m_tready;

	// The drain ends once both distance stages are empty.
	function automatic logic pipe_busy();
		pipe_busy = drain_cnt_q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q <= 1'b0;
		end else begin
			drain_cnt_q <= state_q == ST_SEARCH;
		end
	end

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						if (s_tuser && (s_tdata == '0)) begin
							state_q <= ST_DONE;
						end else if (s_tuser) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_TARGET;
						end
					end
				end
				ST_TARGET: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (last_entry) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!cand_out.valid && (cand_in.valid == 1'b0) && !pipe_busy()) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, target color and running best match.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= s_tuser;
			pix_q        <= s_tdata;
			target_q     <= s_tdata;
			best_dist_q  <= DIST_INIT;
			best_idx_q   <= '0;
			best_color_q <= '0;
		end else begin
			if (state_q == ST_TARGET) begin
				target_q <= rd_color;
			end
			if (cand_out.valid && (cand_dist < best_dist_q)) begin
				best_dist_q  <= cand_dist;
				best_idx_q   <= cand_out.idx;
				best_color_q <= cand_out.color;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= mode_q ? best_color_q : PIX_W'(best_idx_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the light table nearest color search.
module tb;
	import lpnm_pkg::*;

	localparam int TBL_ENTRIES  = DEFAULT_TABLE_ENTRIES;
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 400;
	localparam int MAX_PRINTED  = 40;

	typedef struct {
		bit               mode;
		logic [PIX_W-1:0] pix;
	} pixel_req_t;

	// Clock, reset and block ports.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [PIX_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;

	// Shadow copy of the configuration and the light table built from it.
	int unsigned      red_gain_m   = 1000;
	int unsigned      green_gain_m = 1000;
	int unsigned      blue_gain_m  = 1000;
	bit               tint_m       = 1'b0;
	logic [PIX_W-1:0] light_tbl [256];

	pixel_req_t       pixel_backlog [$];
	logic [PIX_W-1:0] expected_pixels [$];
	int unsigned      n_pushed   = 0;
	int unsigned      n_results  = 0;
	int unsigned      n_errors   = 0;
	int unsigned      cycles     = 0;
	int unsigned      send_gap   = 0;
	int unsigned      stall_left = 0;
	bit               quiet_bus  = 1'b0;

	lit_palette_nearest_match #(
		.TABLE_ENTRIES(TBL_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// One scaled color component, clamped to its field.
	function automatic int unsigned scaled_level(int unsigned c, int unsigned gain,
			int unsigned maxv);
		int unsigned v;
		if (tint_m) begin
			v = (c * 500 + gain * 50) / 1000;
		end else begin
			v = (c * gain) / 1000;
		end
		return (v > maxv) ? maxv : v;
	endfunction

	// Rebuild all 256 table colors; entries past the searched range still serve
	// as targets in index mode.
	function automatic void rebuild_light_table();
		int unsigned r;
		int unsigned g;
		int unsigned b;
		for (int i = 0; i < 256; i++) begin
			r = scaled_level((i & 'hE0) >> 2, red_gain_m, 31);
			g = scaled_level((i & 'h1C) << 1, green_gain_m, 63);
			b = scaled_level((i & 'h03) << 3, blue_gain_m, 31);
			light_tbl[8'(i)] = {r[4:0], g[5:0], b[4:0]};
		end
	endfunction

	function automatic int unsigned color_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
			int unsigned w_rb, int unsigned w_g);
		int dr;
		int dg;
		int db;
		dr = int'(a[15:11]) - int'(b[15:11]);
		dg = int'(a[10:5]) - int'(b[10:5]);
		db = int'(a[4:0]) - int'(b[4:0]);
		return (dr * dr) * w_rb + (dg * dg) * w_g + (db * db) * w_rb;
	endfunction

	// Expected result for one pixel under the current configuration.
	function automatic logic [PIX_W-1:0] nearest_match(bit mode, logic [PIX_W-1:0] pix);
		logic [PIX_W-1:0] target;
		int unsigned      w_rb;
		int unsigned      w_g;
		int unsigned      best_d;
		int unsigned      d;
		int               best_i;
		if (mode && pix == '0) begin
			return '0;
		end
		if (mode) begin
			target = pix;
			w_rb   = 2;
			w_g    = 4;
		end else begin
			target = light_tbl[pix[7:0]];
			w_rb   = 1;
			w_g    = 1;
		end
		best_d = 32'h7FFF_FFFF;
		best_i = 0;
		// Strict compare keeps the lowest index on equal distances.
		for (int i = 0; i < TBL_ENTRIES; i++) begin
			d = color_gap(target, light_tbl[8'(i)], w_rb, w_g);
			if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		return mode ? light_tbl[8'(best_i)] : PIX_W'(best_i);
	endfunction

	// Idle stretch length: mostly short, now and then long.
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 16);
		end
		return $urandom_range(30, 400);
	endfunction

	task automatic flag_mismatch(string what);
		if (n_errors < MAX_PRINTED) begin
			$display("mismatch at cycle %0d: %s", cycles, what);
		end
		n_errors++;
	endtask

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Pixel driver: predicts each accepted request and feeds the next one, at times after an idle gap.
	always @(posedge clk) begin : pixel_driver
		pixel_req_t req;
		if (s_tvalid && s_tready) begin
			expected_pixels.push_back(nearest_match(s_tuser, s_tdata));
		end
		if (!(s_tvalid && !s_tready)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pixel_backlog.size() > 0) begin
				req = pixel_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= req.pix;
				s_tuser  <= req.mode;
				send_gap = (quiet_bus || $urandom_range(0, 1)) ? 0 : idle_span();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result stalls on the receiving side.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (arst_n && !quiet_bus && $urandom_range(0, 99) < 4) begin
			stall_left = idle_span() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result monitor: compares against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		logic [PIX_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_pixels.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want) begin
					flag_mismatch($sformatf("pixel_out %h, expected %h", m_tdata, want));
				end
			end
		end
	end

	task automatic push_pixel(bit mode, logic [PIX_W-1:0] pix);
		pixel_req_t req;
		req.mode = mode;
		req.pix  = pix;
		pixel_backlog.push_back(req);
		n_pushed++;
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write of a batch.
	task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RED_GAIN: begin
				red_gain_m = 32'(data);
			end
			REG_GREEN_GAIN: begin
				green_gain_m = 32'(data);
			end
			REG_BLUE_GAIN: begin
				blue_gain_m = 32'(data);
			end
			REG_TINT_MODE: begin
				tint_m = data[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		while (n_results < n_pushed) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 11'd0;
			1: return 11'd2047;
			2: return 11'd2000;
			3: return 11'd1000;
			4, 5, 6: return GAIN_W'($urandom_range(0, 2047));
			default: return GAIN_W'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic push_random_pixel();
		int unsigned r;
		bit          mode;
		mode = 1'($urandom_range(0, 1));
		r    = $urandom_range(0, 99);
		if (r < 55) begin
			push_pixel(mode, PIX_W'($urandom));
		end else if (r < 65) begin
			push_pixel(mode, '0);
		end else if (r < 80) begin
			// Exact hit on a table color.
			push_pixel(1'b1, light_tbl[8'($urandom_range(0, 255))]);
		end else if (r < 90) begin
			case ($urandom_range(0, 5))
				0: push_pixel(mode, 16'hFFFF);
				1: push_pixel(mode, 16'h0001);
				2: push_pixel(mode, 16'hF800);
				3: push_pixel(mode, 16'h07E0);
				4: push_pixel(mode, 16'h001F);
				default: push_pixel(mode, 16'hFFFE);
			endcase
		end else begin
			push_pixel(mode, PIX_W'(1) << $urandom_range(0, 15));
		end
	endtask

	// Test sequence: reset, directed pixels, then phases of settings and random pixels.
	initial begin : sequencer
		logic [GAIN_W-1:0] rg;
		logic [GAIN_W-1:0] gg;
		logic [GAIN_W-1:0] bg;
		logic [GAIN_W-1:0] tint_word;
		rebuild_light_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels under the reset configuration.
		push_pixel(1'b0, 16'h0000);
		push_pixel(1'b0, 16'h00FF);
		push_pixel(1'b0, 16'h0080);
		push_pixel(1'b0, 16'h001C);
		push_pixel(1'b0, 16'h0003);
		push_pixel(1'b0, 16'hFF00);
		push_pixel(1'b0, 16'hFFFF);
		push_pixel(1'b0, 16'hA5E7);
		push_pixel(1'b1, 16'h0000);
		push_pixel(1'b1, 16'hFFFF);
		push_pixel(1'b1, 16'h0001);
		push_pixel(1'b1, 16'hF800);
		push_pixel(1'b1, 16'h07E0);
		push_pixel(1'b1, 16'h001F);
		push_pixel(1'b1, 16'h8000);
		push_pixel(1'b1, 16'h0020);
		push_pixel(1'b1, 16'h7BEF);
		push_pixel(1'b1, 16'h8410);
		push_pixel(1'b1, 16'h5555);
		push_pixel(1'b1, 16'hAAAA);
		wait_drained();

		for (int p = 1; p <= PHASES; p++) begin
			// Extreme settings first: all-equal tables force ties, then saturation.
			case (p)
				1: begin
					rg = 11'd0; gg = 11'd0; bg = 11'd0; tint_word = 11'h000;
				end
				2: begin
					rg = 11'd2047; gg = 11'd2047; bg = 11'd2047; tint_word = 11'h7FE;
				end
				3: begin
					rg = 11'd0; gg = 11'd0; bg = 11'd0; tint_word = 11'h001;
				end
				4: begin
					rg = 11'd2047; gg = 11'd2047; bg = 11'd2047; tint_word = 11'h7FF;
				end
				5: begin
					rg = 11'd2000; gg = 11'd2000; bg = 11'd2000; tint_word = 11'h000;
				end
				default: begin
					rg        = pick_gain();
					gg        = pick_gain();
					bg        = pick_gain();
					tint_word = GAIN_W'($urandom_range(0, 2047));
				end
			endcase
			quiet_bus = (p % 4 == 3);
			write_reg(REG_RED_GAIN, rg);
			write_reg(REG_GREEN_GAIN, gg);
			write_reg(REG_BLUE_GAIN, bg);
			write_reg(REG_TINT_MODE, tint_word);
			cfg_valid <= 1'b0;
			rebuild_light_table();
			repeat (PHASE_ITEMS) push_random_pixel();
			wait_drained();
		end

		// Catch stray results before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_pixels.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
